// File: rtl/core/mkt_pkg.sv
// ----------------------------------------------------------------------------
// mkt_pkg
// Shared types, key codes and letter tables for the multi-tap text entry block.
// ----------------------------------------------------------------------------
package mkt_pkg;

    localparam int MAX_CHARS = 64;
    localparam int CNT_W     = $clog2(MAX_CHARS + 1);
    localparam int KEY_W     = 4;
    localparam int TIME_W    = 32;
    localparam int TMO_W     = 16;
    localparam int TAP_W     = 3;
    localparam int POS_W     = 6;
    localparam int CHAR_W    = 8;
    localparam int LEN_W     = 7;
    localparam int ACT_W     = 3;

    localparam logic [KEY_W-1:0] KEY_STAR  = 4'd10;
    localparam logic [KEY_W-1:0] KEY_POUND = 4'd11;
    localparam logic [KEY_W-1:0] KEY_OK    = 4'd12;

    localparam logic [TMO_W-1:0] TMO_RESET = 16'd10;

    typedef enum logic [ACT_W-1:0] {
        ACT_NEW     = 3'd0,
        ACT_REPLACE = 3'd1,
        ACT_ERASE   = 3'd2,
        ACT_END     = 3'd3,
        ACT_FULL    = 3'd4
    } t_action;

    typedef enum logic [1:0] {
        KIND_TAP,
        KIND_ERASE,
        KIND_END
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [KEY_W-1:0]   key;
        logic [TIME_W-1:0]  now;
        logic [TAP_W-1:0]   glen;
    } t_entry;

    // Number of characters in a key's letter group; keys without a group
    // behave as a group of one.
    function automatic logic [TAP_W-1:0] group_len(input logic [KEY_W-1:0] k);
        logic [TAP_W-1:0] len;
        case (k)
            4'd0:    len = 3'd2;
            4'd7:    len = 3'd5;
            4'd9:    len = 3'd5;
            4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd8: len = 3'd4;
            default: len = 3'd1;
        endcase
        return len;
    endfunction

    function automatic logic [CHAR_W-1:0] key_char(input logic [KEY_W-1:0] k,
                                                   input logic [TAP_W-1:0] t);
        logic [CHAR_W-1:0] c;
        c = "]";
        case (k)
            4'd0: case (t) 3'd0: c = " "; default: c = "0"; endcase
            4'd1: case (t) 3'd0: c = "."; 3'd1: c = ","; 3'd2: c = "?"; default: c = "1"; endcase
            4'd2: case (t) 3'd0: c = "a"; 3'd1: c = "b"; 3'd2: c = "c"; default: c = "2"; endcase
            4'd3: case (t) 3'd0: c = "d"; 3'd1: c = "e"; 3'd2: c = "f"; default: c = "3"; endcase
            4'd4: case (t) 3'd0: c = "g"; 3'd1: c = "h"; 3'd2: c = "i"; default: c = "4"; endcase
            4'd5: case (t) 3'd0: c = "j"; 3'd1: c = "k"; 3'd2: c = "l"; default: c = "5"; endcase
            4'd6: case (t) 3'd0: c = "m"; 3'd1: c = "n"; 3'd2: c = "o"; default: c = "6"; endcase
            4'd7: case (t)
                3'd0: c = "p"; 3'd1: c = "q"; 3'd2: c = "r"; 3'd3: c = "s"; default: c = "7";
            endcase
            4'd8: case (t) 3'd0: c = "t"; 3'd1: c = "u"; 3'd2: c = "v"; default: c = "8"; endcase
            4'd9: case (t)
                3'd0: c = "w"; 3'd1: c = "x"; 3'd2: c = "y"; 3'd3: c = "z"; default: c = "9";
            endcase
            default: c = "]";
        endcase
        return c;
    endfunction

endpackage

// File: rtl/core/mkt_if.sv
// ----------------------------------------------------------------------------
// mkt_in_if / mkt_out_if
// Valid/ready channels for key items and entry result items.
// ----------------------------------------------------------------------------
interface mkt_in_if;
    logic                         valid;
    logic                         ready;
    logic [mkt_pkg::KEY_W-1:0]    key;
    logic [mkt_pkg::TIME_W-1:0]   now_ticks;

    modport source (output valid, output key, output now_ticks, input ready);
    modport sink   (input valid, input key, input now_ticks, output ready);
endinterface

interface mkt_out_if;
    logic                         valid;
    logic                         ready;
    logic [mkt_pkg::ACT_W-1:0]    action;
    logic [mkt_pkg::POS_W-1:0]    position;
    logic [mkt_pkg::CHAR_W-1:0]   character;
    logic [mkt_pkg::LEN_W-1:0]    length;

    modport source (output valid, output action, output position, output character,
                    output length, input ready);
    modport sink   (input valid, input action, input position, input character,
                    input length, output ready);
endinterface

// File: rtl/core/mkt_front.sv
// ----------------------------------------------------------------------------
// mkt_front
// Accepts key items and classifies them into tap, erase and end commands.
// ----------------------------------------------------------------------------
module mkt_front (
    mkt_in_if.sink          i_item,
    input  logic            i_q_ready,
    output logic            o_push,
    output mkt_pkg::t_entry o_entry
);

    assign i_item.ready = i_q_ready;
    assign o_push       = i_item.valid;

    always_comb begin
        o_entry.key  = i_item.key;
        o_entry.now  = i_item.now_ticks;
        o_entry.glen = mkt_pkg::group_len(i_item.key);
        if (i_item.key == mkt_pkg::KEY_POUND) begin
            o_entry.kind = mkt_pkg::KIND_ERASE;
        end else if (i_item.key == mkt_pkg::KEY_STAR || i_item.key == mkt_pkg::KEY_OK) begin
            o_entry.kind = mkt_pkg::KIND_END;
        end else begin
            o_entry.kind = mkt_pkg::KIND_TAP;
        end
    end

endmodule

// File: rtl/core/mkt_queue.sv
// ----------------------------------------------------------------------------
// mkt_queue
// Two-entry command queue between the classifier and the entry state.
// ----------------------------------------------------------------------------
module mkt_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  mkt_pkg::t_entry i_entry,
    output logic            o_ready,
    input  logic            i_pop,
    output logic            o_valid,
    output mkt_pkg::t_entry o_entry
);

    mkt_pkg::t_entry r_mem [2];
    logic            r_wptr, n_wptr;
    logic            r_rptr, n_rptr;
    logic [1:0]      r_cnt, n_cnt;
    logic            w_do_push;
    logic            w_do_pop;

    assign o_ready   = (r_cnt != 2'd2);
    assign o_valid   = (r_cnt != 2'd0);
    assign o_entry   = r_mem[r_rptr];
    assign w_do_push = i_push && o_ready;
    assign w_do_pop  = i_pop && o_valid;

    always_comb begin
        n_wptr = w_do_push ? ~r_wptr : r_wptr;
        n_rptr = w_do_pop ? ~r_rptr : r_rptr;
        n_cnt  = r_cnt;
        if (w_do_push && !w_do_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (w_do_pop && !w_do_push) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wptr] <= i_entry;
        end
    end

endmodule

// File: rtl/core/mkt_back.sv
// ----------------------------------------------------------------------------
// mkt_back
// Holds the entry state, carries out each command and registers the result.
// ----------------------------------------------------------------------------
module mkt_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [mkt_pkg::TMO_W-1:0]   i_cfg_wdata,
    input  logic                        i_q_valid,
    input  mkt_pkg::t_entry             i_entry,
    output logic                        o_pop,
    mkt_out_if.source                   o_result
);

    logic [mkt_pkg::TMO_W-1:0]  r_timeout;
    logic [mkt_pkg::CNT_W-1:0]  r_count, n_count;
    logic [mkt_pkg::KEY_W-1:0]  r_last_key, n_last_key;
    logic [mkt_pkg::TAP_W-1:0]  r_tap, n_tap;
    logic [mkt_pkg::TIME_W-1:0] r_last_time, n_last_time;

    logic                       r_out_valid, n_out_valid;
    mkt_pkg::t_action           r_action, n_action;
    logic [mkt_pkg::POS_W-1:0]  r_position, n_position;
    logic [mkt_pkg::CHAR_W-1:0] r_character, n_character;
    logic [mkt_pkg::LEN_W-1:0]  r_length, n_length;

    logic [mkt_pkg::TIME_W-1:0] w_elapsed;
    logic                       w_start_new;
    logic                       w_emit;
    logic [mkt_pkg::TAP_W:0]    w_tap_inc;
    logic [mkt_pkg::TAP_W-1:0]  w_tap_next;
    logic [mkt_pkg::CNT_W-1:0]  w_count_dec;
    logic [mkt_pkg::CNT_W-1:0]  w_count_inc;

    // The output register is free when empty or being taken this cycle.
    assign o_pop = i_q_valid && (!r_out_valid || o_result.ready);

    assign w_elapsed   = i_entry.now - r_last_time;
    assign w_start_new = (i_entry.key != r_last_key)
                      || (w_elapsed > {{(mkt_pkg::TIME_W-mkt_pkg::TMO_W){1'b0}}, r_timeout})
                      || (r_count == '0);
    assign w_tap_inc   = {1'b0, r_tap} + 4'd1;
    assign w_tap_next  = (w_tap_inc >= {1'b0, i_entry.glen}) ? '0 : w_tap_inc[mkt_pkg::TAP_W-1:0];
    assign w_count_dec = r_count - 1'b1;
    assign w_count_inc = r_count + 1'b1;

    always_comb begin
        n_count     = r_count;
        n_last_key  = r_last_key;
        n_tap       = r_tap;
        n_last_time = r_last_time;
        n_action    = r_action;
        n_position  = r_position;
        n_character = r_character;
        n_length    = r_length;
        w_emit      = 1'b0;
        if (o_pop) begin
            case (i_entry.kind)
                mkt_pkg::KIND_ERASE: begin
                    // Erasing an empty entry is silently dropped.
                    if (r_count != '0) begin
                        w_emit      = 1'b1;
                        n_count     = w_count_dec;
                        n_last_key  = mkt_pkg::KEY_STAR;
                        n_action    = mkt_pkg::ACT_ERASE;
                        n_position  = w_count_dec[mkt_pkg::POS_W-1:0];
                        n_character = '0;
                        n_length    = w_count_dec[mkt_pkg::LEN_W-1:0];
                    end
                end
                mkt_pkg::KIND_END: begin
                    w_emit      = 1'b1;
                    n_count     = '0;
                    n_tap       = '0;
                    n_last_key  = mkt_pkg::KEY_STAR;
                    n_action    = mkt_pkg::ACT_END;
                    n_position  = '0;
                    n_character = '0;
                    n_length    = '0;
                end
                default: begin
                    w_emit = 1'b1;
                    if (w_start_new) begin
                        if (r_count >= mkt_pkg::CNT_W'(mkt_pkg::MAX_CHARS)) begin
                            n_action    = mkt_pkg::ACT_FULL;
                            n_position  = '0;
                            n_character = '0;
                            n_length    = r_count[mkt_pkg::LEN_W-1:0];
                        end else begin
                            n_tap       = '0;
                            n_last_key  = i_entry.key;
                            n_last_time = i_entry.now;
                            n_count     = w_count_inc;
                            n_action    = mkt_pkg::ACT_NEW;
                            n_position  = r_count[mkt_pkg::POS_W-1:0];
                            n_character = mkt_pkg::key_char(i_entry.key, '0);
                            n_length    = w_count_inc[mkt_pkg::LEN_W-1:0];
                        end
                    end else begin
                        n_tap       = w_tap_next;
                        n_last_time = i_entry.now;
                        n_action    = mkt_pkg::ACT_REPLACE;
                        n_position  = w_count_dec[mkt_pkg::POS_W-1:0];
                        n_character = mkt_pkg::key_char(i_entry.key, w_tap_next);
                        n_length    = r_count[mkt_pkg::LEN_W-1:0];
                    end
                end
            endcase
        end
        if (w_emit) begin
            n_out_valid = 1'b1;
        end else if (o_result.ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout   <= mkt_pkg::TMO_RESET;
            r_count     <= '0;
            r_last_key  <= mkt_pkg::KEY_STAR;
            r_tap       <= '0;
            r_last_time <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_timeout <= i_cfg_wdata;
            end
            r_count     <= n_count;
            r_last_key  <= n_last_key;
            r_tap       <= n_tap;
            r_last_time <= n_last_time;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_action    <= n_action;
        r_position  <= n_position;
        r_character <= n_character;
        r_length    <= n_length;
    end

    assign o_result.valid     = r_out_valid;
    assign o_result.action    = r_action;
    assign o_result.position  = r_position;
    assign o_result.character = r_character;
    assign o_result.length    = r_length;

endmodule

// File: rtl/core/multitap_keypad_text_entry.sv
// A key item waits in the command queue; its result item is registered once
// the output register is free. Throughput: one key item per cycle while results
// are taken; the back stage updates entry length, last key, taps, last time.
// Reset (synchronous, active low): entry empty, last key star, tap timeout 10,
// command queue and output register empty.
// ----------------------------------------------------------------------------
// multitap_keypad_text_entry
// Multi-tap keypad text entry: classifier, command queue and entry state.
// ----------------------------------------------------------------------------
module multitap_keypad_text_entry (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [mkt_pkg::TMO_W-1:0]   i_cfg_wdata,
    mkt_in_if.sink                      i_item,
    mkt_out_if.source                   o_result
);

    logic            w_push;
    logic            w_q_ready;
    mkt_pkg::t_entry w_push_entry;
    logic            w_pop;
    logic            w_q_valid;
    mkt_pkg::t_entry w_pop_entry;

    mkt_front u_front (
        .i_item    (i_item),
        .i_q_ready (w_q_ready),
        .o_push    (w_push),
        .o_entry   (w_push_entry)
    );

    mkt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_push_entry),
        .o_ready (w_q_ready),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_entry (w_pop_entry)
    );

    mkt_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_q_valid   (w_q_valid),
        .i_entry     (w_pop_entry),
        .o_pop       (w_pop),
        .o_result    (o_result)
    );

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the multi-tap keypad text entry block. A scripted
// key sequence and a key fill up to the full entry come first. Random phases
// follow under several tap timeouts and idle patterns. Every result item is
// checked against a local model of the entry state or a scripted result.
// ----------------------------------------------------------------------------
module testbench;

    typedef struct packed {
        mkt_pkg::t_action                 act;
        logic [mkt_pkg::POS_W-1:0]        pos;
        logic [mkt_pkg::CHAR_W-1:0]       ch;
        logic [mkt_pkg::LEN_W-1:0]        len;
    } t_entry_result;

    typedef struct {
        logic [mkt_pkg::KEY_W-1:0]        key;
        logic [mkt_pkg::TIME_W-1:0]       now;
        bit                               typed;
        bit                               silent;
        t_entry_result                    res;
    } t_key_row;

    localparam t_entry_result NO_RES = '{mkt_pkg::ACT_NEW, 6'd0, 8'd0, 7'd0};
    localparam logic [mkt_pkg::KEY_W-1:0] KEY_OTHER_LO = 4'd13;
    localparam logic [mkt_pkg::KEY_W-1:0] KEY_OTHER_HI = 4'd15;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [mkt_pkg::TMO_W-1:0] cfg_wdata;

    mkt_in_if  key_if();
    mkt_out_if res_if();

    multitap_keypad_text_entry uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_item      (key_if),
        .o_result    (res_if)
    );

    always #5 clk = ~clk;

    // Model of the entry state.
    string                        letter_groups [10] = '{" 0", ".,?1", "abc2", "def3", "ghi4",
                                                         "jkl5", "mno6", "pqrs7", "tuv8",
                                                         "wxyz9"};
    int                           entry_len;
    logic [mkt_pkg::KEY_W-1:0]    prev_key;
    int                           tap_idx;
    logic [mkt_pkg::TIME_W-1:0]   prev_time;
    logic [mkt_pkg::TMO_W-1:0]    tap_tmo;

    t_entry_result     pending [$];
    t_entry_result     want;
    int                sender_idle_pct;
    int                sink_stall_pct;
    int                err_count;

    t_key_row script [25] = '{
        '{mkt_pkg::KEY_POUND, 32'd0,   1'b1, 1'b1, NO_RES},
        '{4'd2,      32'd100, 1'b1, 1'b0, '{mkt_pkg::ACT_NEW, 6'd0, "a", 7'd1}},
        '{4'd2,      32'd105, 1'b0, 1'b0, NO_RES},
        '{4'd2,      32'd115, 1'b0, 1'b0, NO_RES},
        '{4'd2,      32'd126, 1'b0, 1'b0, NO_RES},
        '{4'd7,      32'd127, 1'b0, 1'b0, NO_RES},
        '{4'd7,      32'd128, 1'b0, 1'b0, NO_RES},
        '{4'd7,      32'd129, 1'b0, 1'b0, NO_RES},
        '{4'd7,      32'd130, 1'b0, 1'b0, NO_RES},
        '{4'd7,      32'd131, 1'b0, 1'b0, NO_RES},
        '{4'd7,      32'd132, 1'b0, 1'b0, NO_RES},
        '{4'd0,      32'd140, 1'b0, 1'b0, NO_RES},
        '{4'd0,      32'd141, 1'b0, 1'b0, NO_RES},
        '{4'd0,      32'd142, 1'b0, 1'b0, NO_RES},
        '{KEY_OTHER_LO, 32'd143, 1'b0, 1'b0, NO_RES},
        '{KEY_OTHER_LO, 32'd144, 1'b0, 1'b0, NO_RES},
        '{KEY_OTHER_HI, 32'd145, 1'b0, 1'b0, NO_RES},
        '{4'd14,     32'd146, 1'b0, 1'b0, NO_RES},
        '{mkt_pkg::KEY_POUND, 32'd147, 1'b0, 1'b0, NO_RES},
        '{4'd14,     32'd148, 1'b0, 1'b0, NO_RES},
        '{mkt_pkg::KEY_OK, 32'd150, 1'b1, 1'b0, '{mkt_pkg::ACT_END, 6'd0, 8'd0, 7'd0}},
        '{4'd1,      32'hFFFF_FFFA, 1'b1, 1'b0, '{mkt_pkg::ACT_NEW, 6'd0, ".", 7'd1}},
        '{4'd1,      32'h0000_0004, 1'b0, 1'b0, NO_RES},
        '{4'd9,      32'hFFFF_FFFF, 1'b0, 1'b0, NO_RES},
        '{mkt_pkg::KEY_STAR, 32'd0, 1'b1, 1'b0, '{mkt_pkg::ACT_END, 6'd0, 8'd0, 7'd0}}
    };

    function automatic logic [mkt_pkg::CHAR_W-1:0] glyph(input logic [mkt_pkg::KEY_W-1:0] k,
                                                         input int taps);
        if (k < 4'd10) begin
            return letter_groups[k][taps];
        end
        return "]";
    endfunction

    function automatic int group_size(input logic [mkt_pkg::KEY_W-1:0] k);
        return (k < 4'd10) ? letter_groups[k].len() : 1;
    endfunction

    // Applies one key to the model entry; returns 0 when the key gives no result.
    function automatic bit apply_key(input logic [mkt_pkg::KEY_W-1:0] k,
                                     input logic [mkt_pkg::TIME_W-1:0] t,
                                     output t_entry_result r);
        logic [mkt_pkg::TIME_W-1:0] elapsed;
        bit fresh;
        r = NO_RES;
        if (k == mkt_pkg::KEY_POUND) begin
            if (entry_len == 0) begin
                return 1'b0;
            end
            entry_len--;
            prev_key = mkt_pkg::KEY_STAR;
            r = '{mkt_pkg::ACT_ERASE, mkt_pkg::POS_W'(entry_len), 8'd0,
                  mkt_pkg::LEN_W'(entry_len)};
            return 1'b1;
        end
        if (k == mkt_pkg::KEY_STAR || k == mkt_pkg::KEY_OK) begin
            entry_len = 0;
            tap_idx = 0;
            prev_key = mkt_pkg::KEY_STAR;
            r = '{mkt_pkg::ACT_END, 6'd0, 8'd0, 7'd0};
            return 1'b1;
        end
        elapsed = t - prev_time;
        fresh = (k != prev_key) || (elapsed > mkt_pkg::TIME_W'(tap_tmo)) || (entry_len == 0);
        if (fresh) begin
            if (entry_len >= mkt_pkg::MAX_CHARS) begin
                r = '{mkt_pkg::ACT_FULL, 6'd0, 8'd0, mkt_pkg::LEN_W'(entry_len)};
                return 1'b1;
            end
            tap_idx = 0;
            prev_key = k;
            prev_time = t;
            r = '{mkt_pkg::ACT_NEW, mkt_pkg::POS_W'(entry_len), glyph(k, 0),
                  mkt_pkg::LEN_W'(entry_len + 1)};
            entry_len++;
            return 1'b1;
        end
        tap_idx = (tap_idx + 1) % group_size(k);
        prev_time = t;
        r = '{mkt_pkg::ACT_REPLACE, mkt_pkg::POS_W'(entry_len - 1), glyph(k, tap_idx),
              mkt_pkg::LEN_W'(entry_len)};
        return 1'b1;
    endfunction

    // A tick time inside the tap window after the last tap, past it, or at random.
    function automatic logic [mkt_pkg::TIME_W-1:0] tick_after(input bit inside_window);
        if (inside_window) begin
            if ($urandom_range(3) == 0) begin
                return prev_time + mkt_pkg::TIME_W'(tap_tmo);
            end
            return prev_time + mkt_pkg::TIME_W'($urandom_range(tap_tmo));
        end
        case ($urandom_range(3))
            0:       return prev_time + mkt_pkg::TIME_W'(tap_tmo) + 1;
            1:       return $urandom;
            default: return prev_time + mkt_pkg::TIME_W'(tap_tmo) + 1
                            + mkt_pkg::TIME_W'($urandom_range(1000));
        endcase
    endfunction

    task automatic send_key(input logic [mkt_pkg::KEY_W-1:0] k,
                            input logic [mkt_pkg::TIME_W-1:0] t,
                            input bit typed = 1'b0, input bit silent = 1'b0,
                            input t_entry_result res = NO_RES);
        t_entry_result predicted;
        bit produced;
        while ($urandom_range(99) < sender_idle_pct) begin
            key_if.valid <= 1'b0;
            @(posedge clk);
        end
        key_if.valid     <= 1'b1;
        key_if.key       <= k;
        key_if.now_ticks <= t;
        do @(posedge clk); while (!key_if.ready);
        produced = apply_key(k, t, predicted);
        if (typed) begin
            if (!silent) begin
                pending.push_back(res);
            end
        end else if (produced) begin
            pending.push_back(predicted);
        end
    endtask

    // Lets the block go quiet; a pound on an empty entry gives no result, so
    // the bench waits on past the last expected item.
    task automatic drain();
        key_if.valid <= 1'b0;
        while (pending.size() != 0) begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic write_timeout(input logic [mkt_pkg::TMO_W-1:0] value);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        tap_tmo = value;
    endtask

    task automatic run_random(input int n_items, input int end_pct);
        int sent;
        int r;
        int taps;
        logic [mkt_pkg::KEY_W-1:0] k;
        sent = 0;
        while (sent < n_items) begin
            r = $urandom_range(99);
            if (r < 64) begin
                // One character: a first press, then taps that may cycle the group.
                if ($urandom_range(9) == 0) begin
                    k = mkt_pkg::KEY_W'($urandom_range(KEY_OTHER_HI, KEY_OTHER_LO));
                end else begin
                    k = mkt_pkg::KEY_W'($urandom_range(9));
                end
                taps = ($urandom_range(3) == 0) ? $urandom_range(7, 3) : $urandom_range(2, 1);
                for (int i = 0; i < taps; i++) begin
                    send_key(k, tick_after((i != 0) || ($urandom_range(1) == 1)));
                end
                sent += taps;
            end else if (r < 76) begin
                if (entry_len != 0) begin
                    sent++;
                end
                send_key(mkt_pkg::KEY_POUND, $urandom);
            end else if (r < 76 + end_pct) begin
                send_key(($urandom_range(1) == 1) ? mkt_pkg::KEY_STAR : mkt_pkg::KEY_OK,
                         $urandom);
                sent++;
            end else if (r < 92) begin
                k = mkt_pkg::KEY_W'($urandom_range(15));
                if (k != mkt_pkg::KEY_POUND || entry_len != 0) begin
                    sent++;
                end
                send_key(k, $urandom);
            end else begin
                // Same key again, but late enough to start a new character.
                send_key((prev_key == mkt_pkg::KEY_STAR) ? 4'd5 : prev_key, tick_after(1'b0));
                sent++;
            end
        end
    endtask

    always @(posedge clk) begin
        res_if.ready <= ($urandom_range(99) >= sink_stall_pct);
        if (rst_n && res_if.valid && res_if.ready) begin
            if (pending.size() == 0) begin
                $error("unexpected result item: action %0d position %0d length %0d",
                       res_if.action, res_if.position, res_if.length);
                err_count++;
            end else begin
                want = pending.pop_front();
                if (res_if.action !== want.act) begin
                    $error("action: expected %0d, got %0d", want.act, res_if.action);
                    err_count++;
                end
                if (res_if.position !== want.pos) begin
                    $error("position: expected %0d, got %0d", want.pos, res_if.position);
                    err_count++;
                end
                if (res_if.character !== want.ch) begin
                    $error("character: expected 0x%02h, got 0x%02h", want.ch, res_if.character);
                    err_count++;
                end
                if (res_if.length !== want.len) begin
                    $error("length: expected %0d, got %0d", want.len, res_if.length);
                    err_count++;
                end
            end
        end
    end

    initial begin
        #2_000_000;
        $display("multitap_keypad_text_entry regression: fail");
        $finish;
    end

    initial begin
        logic [mkt_pkg::TIME_W-1:0] t;
        err_count       = 0;
        sender_idle_pct = 0;
        sink_stall_pct  = 0;
        entry_len       = 0;
        prev_key        = mkt_pkg::KEY_STAR;
        tap_idx         = 0;
        prev_time       = '0;
        tap_tmo         = mkt_pkg::TMO_RESET;
        rst_n            <= 1'b0;
        cfg_we           <= 1'b0;
        cfg_wdata        <= '0;
        key_if.valid     <= 1'b0;
        key_if.key       <= '0;
        key_if.now_ticks <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[i]) begin
            send_key(script[i].key, script[i].now, script[i].typed, script[i].silent,
                     script[i].res);
        end

        // Fill the entry, then exercise replace, reject and erase at the top.
        t = 32'd1000;
        for (int i = 0; i < mkt_pkg::MAX_CHARS; i++) begin
            t = t + 1;
            send_key((i % 2 == 1) ? 4'd3 : 4'd4, t);
        end
        send_key(4'd3, t + 2);
        send_key(4'd5, t + 3);
        send_key(4'd3, t + 100);
        send_key(mkt_pkg::KEY_POUND, t + 101);
        send_key(4'd5, t + 102);
        send_key(4'd6, t + 103);
        send_key(mkt_pkg::KEY_OK, t + 104);

        write_timeout(16'd0);
        sender_idle_pct = 27;
        sink_stall_pct  = 76;
        run_random(100, 4);

        write_timeout(16'hFFFF);
        sender_idle_pct = 76;
        sink_stall_pct  = 27;
        run_random(100, 4);

        write_timeout(mkt_pkg::TMO_W'($urandom_range(40, 1)));
        sender_idle_pct = 0;
        sink_stall_pct  = 0;
        run_random(100, 1);

        drain();
        repeat (6) @(posedge clk);
        if (err_count == 0) begin
            $display("multitap_keypad_text_entry regression: pass");
        end else begin
            $display("multitap_keypad_text_entry regression: fail");
        end
        $finish;
    end
endmodule

// File: sim.f
rtl/core/mkt_pkg.sv
rtl/core/mkt_if.sv
rtl/core/mkt_front.sv
rtl/core/mkt_queue.sv
rtl/core/mkt_back.sv
rtl/core/multitap_keypad_text_entry.sv
dv/testbench.sv
